[sv/cdwg_pkg.sv]
// ----------------------------------------------------------------------------
// cdwg_pkg
// Shared types and constants of the drift-compensated wakeup guard.
// ----------------------------------------------------------------------------
package cdwg_pkg;

    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 20;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);
    localparam int DIV_N_W   = PROD_W;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);
    localparam int DRIFT_W   = 17;
    localparam int UNC_W     = 20;
    localparam int GUARD_W   = 43;

    localparam logic [MUL_B_W-1:0] PPM_SCALE      = 20'd1000000;
    localparam logic [16:0]        DRIFT_LIMIT    = 17'd50000;
    localparam logic [31:0]        MIN_SLEEP_MS   = 32'd5000;
    localparam logic [31:0]        SLEEP_FLOOR_MS = 32'd1000;
    localparam logic [7:0]         RANK_INVALID   = 8'd255;
    localparam logic [7:0]         COUNT_MAX      = 8'd255;
    localparam logic [7:0]         MAX_DOUBLINGS  = 8'd8;

    localparam logic [2:0] CFG_INIT_UNC    = 3'd0;
    localparam logic [2:0] CFG_UNC_FLOOR   = 3'd1;
    localparam logic [2:0] CFG_HOP_JITTER  = 3'd2;
    localparam logic [2:0] CFG_GUARD_FLOOR = 3'd3;
    localparam logic [2:0] CFG_GUARD_CEIL  = 3'd4;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_OK      = 2'd1,
        ST_SHORT   = 2'd2,
        ST_OUTLIER = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_SMUL, S_SDIV, S_CORR, S_CMUL, S_CDIV,
        S_GUARD, S_GMUL, S_GDIV, S_DBL, S_FIN
    } t_state;

endpackage

[sv/cdwg_in_if.sv]
// ----------------------------------------------------------------------------
// cdwg_in_if
// Wake event channel: valid/ready plus the event word.
// ----------------------------------------------------------------------------
interface cdwg_in_if;
    logic               valid;
    logic               ready;
    logic               sample_present;
    logic signed [31:0] timing_error_ms;
    logic        [31:0] measured_sleep_ms;
    logic        [31:0] planned_sleep_ms;
    logic        [7:0]  hop_rank;
    logic        [7:0]  missed_beacons;

    modport source (output valid, sample_present, timing_error_ms, measured_sleep_ms,
                    planned_sleep_ms, hop_rank, missed_beacons, input ready);
    modport sink   (input valid, sample_present, timing_error_ms, measured_sleep_ms,
                    planned_sleep_ms, hop_rank, missed_beacons, output ready);
endinterface

[sv/cdwg_out_if.sv]
// ----------------------------------------------------------------------------
// cdwg_out_if
// Result channel: valid/ready plus the result word.
// ----------------------------------------------------------------------------
interface cdwg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] corrected_sleep;
    logic [19:0] drift_uncertainty;
    logic [31:0] listen_guard;
    logic [1:0]  sample_status;

    modport source (output valid, corrected_sleep, drift_uncertainty, listen_guard,
                    sample_status, input ready);
    modport sink   (input valid, corrected_sleep, drift_uncertainty, listen_guard,
                    sample_status, output ready);
endinterface

[sv/cdwg_mul.sv]
// ----------------------------------------------------------------------------
// cdwg_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module cdwg_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cdwg_pkg::MUL_A_W-1:0]   i_a,
    input  logic [cdwg_pkg::MUL_B_W-1:0]   i_b,
    output logic                           o_done,
    output logic [cdwg_pkg::PROD_W-1:0]    o_prod
);
    import cdwg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [PROD_W-1:0]    r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_B_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[PROD_W-2:0], 1'b0}
                   + (r_b[MUL_B_W-1] ? PROD_W'(r_a) : '0);
            r_b   <= {r_b[MUL_B_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[sv/cdwg_div.sv]
// ----------------------------------------------------------------------------
// cdwg_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cdwg_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cdwg_pkg::DIV_N_W-1:0]   i_dividend,
    input  logic [cdwg_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [cdwg_pkg::DIV_N_W-1:0]   o_quot
);
    import cdwg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_d;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_N_W-1:0]   r_q;
    logic [DIV_D_W:0]     trial;
    logic                 q_bit;

    assign trial = {r_rem, r_q[DIV_N_W-1]};
    assign q_bit = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= q_bit ? DIV_D_W'(trial - {1'b0, r_d}) : trial[DIV_D_W-1:0];
            r_q   <= {r_q[DIV_N_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[sv/clock_drift_wakeup_guard.sv]
// ----------------------------------------------------------------------------
// clock_drift_wakeup_guard
// Drift estimate, corrected sleep and listen guard per wake event.
//
//  channel | dir | handshake   | word
//  i_in    | in  | valid/ready | sample, error, measured, planned, rank, misses
//  o_out   | out | valid/ready | corrected sleep, uncertainty, guard, status
//  i_cfg_* | in  | write enable| register index and data
//
//  An event runs the serial multiplier and divider once per product/quotient:
//  for the drift sample if one is usable, for the corrected sleep once
//  calibrated and for the guard always, plus up to 8 doublings.
//  One event at a time; the next is taken once the result sits in the output
//  register. Reset is synchronous and clears state to uncalibrated.
// ----------------------------------------------------------------------------
module clock_drift_wakeup_guard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdwg_in_if.sink     i_in,
    cdwg_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import cdwg_pkg::*;

    t_state r_state, n_state;

    logic [UNC_W-1:0] r_init_unc, r_unc_floor;
    logic [15:0]      r_jitter;
    logic [31:0]      r_gfloor, r_gceil;

    logic signed [DRIFT_W-1:0] r_drift;
    logic [7:0]                r_count;

    logic               r_present;
    logic [31:0]        r_err;
    logic [31:0]        r_slept;
    logic [31:0]        r_planned;
    logic [7:0]         r_rank;
    logic [3:0]         r_dbl;
    t_status            r_status;
    logic [31:0]        r_corr;
    logic [UNC_W-1:0]   r_unc;
    logic [GUARD_W-1:0] r_g;

    logic               r_out_valid;
    logic [31:0]        r_out_corr;
    logic [UNC_W-1:0]   r_out_unc;
    logic [31:0]        r_out_guard;
    t_status            r_out_status;

    logic                mul_start, mul_done, div_start, div_done;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic [DIV_D_W-1:0]  div_divisor;
    logic [DIV_N_W-1:0]  div_quot;
    logic                out_load;
    logic                sample_ok;

    logic [31:0]         err_mag;
    logic [DRIFT_W-1:0]  drift_mag;
    logic [UNC_W-1:0]    unc_now;
    logic                outlier;
    logic [DRIFT_W-1:0]  s_mag;
    logic [18:0]         s3;
    logic signed [18:0]  s_term, est_raw;
    logic signed [DRIFT_W-1:0] est;
    logic [33:0]         adj;
    logic [31:0]         corr_val;
    logic [GUARD_W-1:0]  g_init, g_dbl, g_fl;
    logic [23:0]         hop_add;
    logic [31:0]         guard_val;

    cdwg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    cdwg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // datapath terms
    assign err_mag   = r_err[31] ? 32'(-r_err) : r_err;
    assign drift_mag = r_drift[DRIFT_W-1] ? DRIFT_W'(-r_drift) : DRIFT_W'(r_drift);
    assign unc_now   = (r_count == '0) ? r_init_unc
                     : ((UNC_W'(drift_mag) > r_unc_floor) ? UNC_W'(drift_mag) : r_unc_floor);
    assign sample_ok = r_present && (r_slept >= MIN_SLEEP_MS);

    assign outlier = (div_quot > DIV_N_W'(DRIFT_LIMIT));
    assign s_mag   = div_quot[DRIFT_W-1:0];
    assign s3      = {2'b00, s_mag} + {1'b0, s_mag, 1'b0};
    assign s_term  = (r_count == '0)
                   ? (r_err[31] ? -$signed({2'b00, s_mag}) : $signed({2'b00, s_mag}))
                   : (r_err[31] ? -$signed({2'b00, s3[18:2]}) : $signed({2'b00, s3[18:2]}));
    assign est_raw = ((r_count == '0) ? 19'sd0 : 19'(r_drift)) + s_term;
    always_comb begin
        if (est_raw > $signed({2'b00, DRIFT_LIMIT}))
            est = $signed(DRIFT_LIMIT);
        else if (est_raw < -$signed({2'b00, DRIFT_LIMIT}))
            est = -$signed(DRIFT_LIMIT);
        else
            est = est_raw[DRIFT_W-1:0];
    end

    assign adj = r_drift[DRIFT_W-1] ? ({2'b00, r_planned} - {1'b0, div_quot[32:0]})
                                    : ({2'b00, r_planned} + {1'b0, div_quot[32:0]});
    always_comb begin
        if (adj < 34'(SLEEP_FLOOR_MS))
            corr_val = SLEEP_FLOOR_MS;
        else if (adj[33:32] != 2'b00)
            corr_val = '1;
        else
            corr_val = adj[31:0];
    end

    assign hop_add = (r_rank != RANK_INVALID) ? (24'(r_rank) * 24'(r_jitter)) : '0;
    assign g_init  = GUARD_W'(div_quot[32:0]) + GUARD_W'(hop_add);
    assign g_dbl   = {r_g[GUARD_W-2:0], 1'b0};
    assign g_fl    = (r_g < GUARD_W'(r_gfloor)) ? GUARD_W'(r_gfloor) : r_g;
    assign guard_val = (g_fl > GUARD_W'(r_gceil)) ? r_gceil : g_fl[31:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_CHK;
            S_CHK:   n_state = sample_ok ? S_SMUL : S_CORR;
            S_SMUL:  if (mul_done) n_state = S_SDIV;
            S_SDIV:  if (div_done) n_state = S_CORR;
            S_CORR:  n_state = (r_count == '0) ? S_GUARD : S_CMUL;
            S_CMUL:  if (mul_done) n_state = S_CDIV;
            S_CDIV:  if (div_done) n_state = S_GUARD;
            S_GUARD: n_state = S_GMUL;
            S_GMUL:  if (mul_done) n_state = S_GDIV;
            S_GDIV:  if (div_done) n_state = S_DBL;
            S_DBL:   if (r_dbl == '0) n_state = S_FIN;
            S_FIN:   if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        mul_start   = 1'b0;
        mul_a       = r_planned;
        mul_b       = unc_now;
        div_start   = mul_done;
        div_divisor = (r_state == S_SMUL) ? r_slept : DIV_D_W'(PPM_SCALE);
        out_load    = 1'b0;
        case (r_state)
            S_CHK: begin
                mul_start = sample_ok;
                mul_a     = err_mag;
                mul_b     = PPM_SCALE;
            end
            S_CORR: begin
                mul_start = (r_count != '0);
                mul_b     = MUL_B_W'(drift_mag);
            end
            S_GUARD: mul_start = 1'b1;
            S_FIN:   out_load  = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init_unc  <= 20'd20000;
            r_unc_floor <= 20'd20;
            r_jitter    <= 16'd50;
            r_gfloor    <= 32'd20;
            r_gceil     <= 32'd2000;
            r_drift     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INIT_UNC:    r_init_unc  <= i_cfg_data[UNC_W-1:0];
                    CFG_UNC_FLOOR:   r_unc_floor <= i_cfg_data[UNC_W-1:0];
                    CFG_HOP_JITTER:  r_jitter    <= i_cfg_data[15:0];
                    CFG_GUARD_FLOOR: r_gfloor    <= i_cfg_data;
                    CFG_GUARD_CEIL:  r_gceil     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_SDIV && div_done && !outlier) begin
                r_drift <= est;
                if (r_count != COUNT_MAX) r_count <= r_count + 1'b1;
            end
            if (out_load)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_present <= i_in.sample_present;
            r_err     <= i_in.timing_error_ms;
            r_slept   <= i_in.measured_sleep_ms;
            r_planned <= i_in.planned_sleep_ms;
            r_rank    <= i_in.hop_rank;
            r_dbl     <= (i_in.missed_beacons > MAX_DOUBLINGS) ? MAX_DOUBLINGS[3:0]
                                                               : i_in.missed_beacons[3:0];
        end
        if (r_state == S_CHK)
            r_status <= !r_present ? ST_NONE : (sample_ok ? ST_OK : ST_SHORT);
        if (r_state == S_SDIV && div_done && outlier)
            r_status <= ST_OUTLIER;
        if (r_state == S_CORR && r_count == '0)
            r_corr <= r_planned;
        if (r_state == S_CDIV && div_done)
            r_corr <= corr_val;
        if (r_state == S_GUARD)
            r_unc <= unc_now;
        if (r_state == S_GDIV && div_done)
            r_g <= g_init;
        if (r_state == S_DBL && r_dbl != '0) begin
            r_g   <= g_dbl;
            r_dbl <= (g_dbl >= GUARD_W'(r_gceil)) ? 4'd0 : r_dbl - 1'b1;
        end
        if (out_load) begin
            r_out_corr   <= r_corr;
            r_out_unc    <= r_unc;
            r_out_guard  <= guard_val;
            r_out_status <= r_status;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.corrected_sleep   = r_out_corr;
    assign o_out.drift_uncertainty = r_out_unc;
    assign o_out.listen_guard      = r_out_guard;
    assign o_out.sample_status     = r_out_status;

    a_drift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drift <= $signed(DRIFT_LIMIT)) && (r_drift >= -$signed(DRIFT_LIMIT)))
        else $error("drift estimate out of range");

    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_drift == '0))
        else $error("drift set without accepted sample");

    a_mul_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_SMUL || r_state == S_CMUL || r_state == S_GMUL))
        else $error("multiplier done outside a multiply phase");

    a_div_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_SDIV || r_state == S_CDIV || r_state == S_GDIV))
        else $error("divider done outside a divide phase");

endmodule

[bench/cdwg_tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdwg_tb_if
// Bench-side records of the event channel and the result channel.
// The bench reuses the RTL interfaces; this file only holds the event and result records.
// ----------------------------------------------------------------------------
package cdwg_tb_pkg;
    typedef struct packed {
        logic               sample_present;
        logic signed [31:0] timing_error_ms;
        logic        [31:0] measured_sleep_ms;
        logic        [31:0] planned_sleep_ms;
        logic        [7:0]  hop_rank;
        logic        [7:0]  missed_beacons;
    } t_event;

    typedef struct packed {
        logic [31:0] corrected_sleep;
        logic [19:0] drift_uncertainty;
        logic [31:0] listen_guard;
        logic [1:0]  sample_status;
    } t_result;
endpackage

[bench/tb_clock_drift_wakeup_guard.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clock_drift_wakeup_guard
// Drives wake events, with random gaps except under back-pressure, and checks every result word against
// a cycle-free model of the drift estimate, corrected sleep and guard.
// ----------------------------------------------------------------------------
module tb_clock_drift_wakeup_guard;
    import cdwg_pkg::*;
    import cdwg_tb_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYC  = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    cdwg_in_if  ev_if ();
    cdwg_out_if res_if ();

    clock_drift_wakeup_guard i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (ev_if),
        .o_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // model state
    logic [19:0]        m_init_unc;
    logic [19:0]        m_unc_floor;
    logic [15:0]        m_hop_jitter;
    logic [31:0]        m_guard_floor;
    logic [31:0]        m_guard_ceil;
    logic signed [31:0] m_drift;
    logic [7:0]         m_count;

    t_result expected_words[$];
    int      n_errors;
    int      idle_cycles;
    bit      hold_off;
    bit      long_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result predict_word(t_event ev);
        t_result r;
        longint err, s, est, adj;
        longint unsigned g;
        logic [31:0] unc, mag;
        t_status st;
        st = ST_NONE;
        if (ev.sample_present) begin
            if (ev.measured_sleep_ms < MIN_SLEEP_MS) begin
                st = ST_SHORT;
            end else begin
                err = longint'(ev.timing_error_ms);
                s = (err * 1000000) / longint'({32'd0, ev.measured_sleep_ms});
                if (s > 50000 || s < -50000) begin
                    st = ST_OUTLIER;
                end else begin
                    st = ST_OK;
                    est = (m_count == 0) ? s : longint'(m_drift) + (s * 3) / 4;
                    if (est > 50000) est = 50000;
                    else if (est < -50000) est = -50000;
                    m_drift = 32'(est);
                    if (m_count != COUNT_MAX) m_count = m_count + 8'd1;
                end
            end
        end
        if (m_count == 0) begin
            r.corrected_sleep = ev.planned_sleep_ms;
            unc = 32'(m_init_unc);
        end else begin
            adj = longint'({32'd0, ev.planned_sleep_ms});
            adj = adj + (adj * longint'(m_drift)) / 1000000;
            if (adj < 1000) adj = 1000;
            if (adj > 64'hFFFF_FFFF) adj = 64'hFFFF_FFFF;
            r.corrected_sleep = adj[31:0];
            mag = (m_drift < 0) ? -m_drift : m_drift;
            unc = (mag > 32'(m_unc_floor)) ? mag : 32'(m_unc_floor);
        end
        g = (longint'({32'd0, ev.planned_sleep_ms}) * unc) / 1000000;
        if (ev.hop_rank != RANK_INVALID && ev.hop_rank != 0)
            g += ev.hop_rank * m_hop_jitter;
        for (int i = 0; i < ev.missed_beacons && i < MAX_DOUBLINGS; i++) begin
            g = g * 2;
            if (g >= m_guard_ceil) break;
        end
        if (g < m_guard_floor) g = m_guard_floor;
        if (g > m_guard_ceil) g = m_guard_ceil;
        r.listen_guard      = g[31:0];
        r.drift_uncertainty = unc[19:0];
        r.sample_status     = st;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERR %s got %0d want %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic int gap_len(int max_long);
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, max_long))
                                           : int'($urandom_range(0, 2));
    endfunction

    task automatic send_event(t_event ev, bit gaps);
        int n;
        ev_if.valid             <= 1'b1;
        ev_if.sample_present    <= ev.sample_present;
        ev_if.timing_error_ms   <= ev.timing_error_ms;
        ev_if.measured_sleep_ms <= ev.measured_sleep_ms;
        ev_if.planned_sleep_ms  <= ev.planned_sleep_ms;
        ev_if.hop_rank          <= ev.hop_rank;
        ev_if.missed_beacons    <= ev.missed_beacons;
        do @(posedge i_clk); while (!ev_if.ready);
        expected_words.push_back(predict_word(ev));
        n = gaps ? gap_len(30) : 0;
        if (n != 0) begin
            ev_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_INIT_UNC:    m_init_unc    = val[19:0];
            CFG_UNC_FLOOR:   m_unc_floor   = val[19:0];
            CFG_HOP_JITTER:  m_hop_jitter  = val[15:0];
            CFG_GUARD_FLOOR: m_guard_floor = val;
            CFG_GUARD_CEIL:  m_guard_ceil  = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        ev_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_event make_event(bit sp, int err, int unsigned meas,
                                          int unsigned plan, byte unsigned rk,
                                          byte unsigned ms);
        t_event ev;
        ev.sample_present    = sp;
        ev.timing_error_ms   = err;
        ev.measured_sleep_ms = meas;
        ev.planned_sleep_ms  = plan;
        ev.hop_rank          = rk;
        ev.missed_beacons    = ms;
        return ev;
    endfunction

    function automatic t_event random_event();
        t_event ev;
        int unsigned meas;
        int unsigned ppm;
        ev = make_event($urandom_range(0, 3) != 0, $urandom, $urandom, $urandom,
                        8'($urandom), 8'($urandom));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                // well-formed sample within the drift window
                meas = $urandom_range(5000, 2000000);
                ppm  = $urandom_range(0, 100000);
                ev.measured_sleep_ms = meas;
                ev.timing_error_ms   = 32'((longint'(ppm) - 50000) * meas / 1000000);
            end
            6: ev.measured_sleep_ms = $urandom_range(0, 5000);
            7: ev.planned_sleep_ms  = $urandom_range(0, 100000);
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0) ev.missed_beacons = 8'($urandom_range(0, 10));
        if ($urandom_range(0, 3) == 0) ev.hop_rank = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return ev;
    endfunction

    task automatic test_directed();
        send_event(make_event(0, 0, 0, 0, 0, 0), 1);
        send_event(make_event(1, 100, 4999, 60000, 255, 0), 1);
        send_event(make_event(1, 300, 5000, 60000, 3, 2), 1);        // outlier
        send_event(make_event(1, -250, 5000, 60000, 1, 9), 1);       // first sample
        send_event(make_event(1, 100, 10000, 32'hFFFF_FFFF, 254, 255), 1);
        send_event(make_event(1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 500, 0, 8), 1);
        send_event(make_event(1, 32'h8000_0000, 32'hFFFF_FFFF, 1, 255, 1), 1);
        send_event(make_event(1, 250, 5000, 32'hFFFF_FFFF, 0, 0), 1);
        send_event(make_event(1, 250, 5000, 0, 7, 3), 1);
        send_event(make_event(1, 250, 5000, 1200, 7, 3), 1);
        send_event(make_event(1, -250, 5000, 900, 7, 3), 1);
        send_event(make_event(1, -250, 5000, 900, 7, 3), 1);
        send_event(make_event(1, -250, 5000, 900, 7, 3), 1);
        send_event(make_event(1, -3, 5000, 1000, 7, 3), 1);
        send_event(make_event(0, -1, 32'hFFFF_FFFF, 123456, 128, 4), 1);
        wait_drained();
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_INIT_UNC, 32'd0);
        write_reg(CFG_UNC_FLOOR, 32'd1000000);
        write_reg(CFG_HOP_JITTER, 32'd65535);
        write_reg(CFG_GUARD_FLOOR, 32'd0);
        write_reg(CFG_GUARD_CEIL, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'hDEAD_BEEF);
        for (int i = 0; i < 60; i++) send_event(random_event(), 1);
        wait_drained();
        write_reg(CFG_INIT_UNC, 32'hFFFF_FFFF);
        write_reg(CFG_UNC_FLOOR, 32'd0);
        write_reg(CFG_HOP_JITTER, 32'd0);
        write_reg(CFG_GUARD_FLOOR, 32'hFFFF_FFFF);
        write_reg(CFG_GUARD_CEIL, 32'd0);
        for (int i = 0; i < 40; i++) send_event(random_event(), 1);
        wait_drained();
        write_reg(CFG_GUARD_FLOOR, 32'd100);
        write_reg(CFG_GUARD_CEIL, 32'd50000);
        write_reg(CFG_HOP_JITTER, $urandom_range(0, 65535));
        write_reg(CFG_UNC_FLOOR, $urandom_range(0, 1000));
        for (int i = 0; i < 400; i++) send_event(random_event(), 1);
        wait_drained();
    endtask

    task automatic test_back_pressure();
        hold_off = 1'b1;
        long_hold = 1'b1;
        for (int i = 0; i < 6; i++) send_event(random_event(), 0);
        wait_drained();
        for (int i = 0; i < 50; i++) send_event(random_event(), 0);
        wait_drained();
    endtask

    task automatic test_random();
        write_reg(CFG_INIT_UNC, $urandom_range(0, 1000000));
        write_reg(CFG_GUARD_CEIL, $urandom_range(1000, 3000000));
        for (int i = 0; i < 380; i++) send_event(random_event(), 1);
        wait_drained();
    endtask

    // result side: random stalls, one long hold when requested
    initial begin
        int n;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                res_if.ready <= 1'b0;
                repeat (1500) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!hold_off && $urandom_range(0, 7) == 0) begin
                n = gap_len(40);
                if (n != 0) begin
                    res_if.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", res_if.listen_guard, 0);
            end else begin
                want = expected_words.pop_front();
                if (res_if.corrected_sleep !== want.corrected_sleep)
                    report_mismatch("corrected_sleep", res_if.corrected_sleep,
                                    want.corrected_sleep);
                if (res_if.drift_uncertainty !== want.drift_uncertainty)
                    report_mismatch("drift_uncertainty", 32'(res_if.drift_uncertainty),
                                    32'(want.drift_uncertainty));
                if (res_if.listen_guard !== want.listen_guard)
                    report_mismatch("listen_guard", res_if.listen_guard,
                                    want.listen_guard);
                if (res_if.sample_status !== want.sample_status)
                    report_mismatch("sample_status", 32'(res_if.sample_status),
                                    32'(want.sample_status));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("clock_drift_wakeup_guard: mismatch");
            $finish;
        end
    end

    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        hold_off    = 1'b0;
        long_hold   = 1'b0;
        m_init_unc    = 20'd20000;
        m_unc_floor   = 20'd20;
        m_hop_jitter  = 16'd50;
        m_guard_floor = 32'd20;
        m_guard_ceil  = 32'd2000;
        m_drift       = 0;
        m_count       = 8'd0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= 3'd0;
        i_cfg_data <= 32'd0;
        ev_if.valid             <= 1'b0;
        ev_if.sample_present    <= 1'b0;
        ev_if.timing_error_ms   <= 32'd0;
        ev_if.measured_sleep_ms <= 32'd0;
        ev_if.planned_sleep_ms  <= 32'd0;
        ev_if.hop_rank          <= 8'd0;
        ev_if.missed_beacons    <= 8'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_back_pressure();
        hold_off = 1'b0;
        test_random();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0 && expected_words.size() == 0)
            $display("clock_drift_wakeup_guard: match");
        else
            $display("clock_drift_wakeup_guard: mismatch");
        $finish;
    end
endmodule

[filelist.f]
sv/cdwg_pkg.sv
sv/cdwg_in_if.sv
sv/cdwg_out_if.sv
sv/cdwg_mul.sv
sv/cdwg_div.sv
sv/clock_drift_wakeup_guard.sv
bench/cdwg_tb_if.sv
bench/tb_clock_drift_wakeup_guard.sv
